### sv/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

  localparam int unsigned LenWidth = 61;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // byte write source selection
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } src_t;

  // controller to datapath commands
  typedef struct packed {
    logic       put;       // write one byte into the schedule window
    src_t       src;
    logic       count_len; // count one message byte
    logic       load;      // load working vars from chaining value
    logic       round;     // run one round
    logic       update;    // add working vars into chaining value
    logic       reinit;    // restore initial chaining value and counters
    logic       emit;      // present digest word at emit index
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       full;      // buffer filled by this put
    logic [5:0] fill;
    logic       last_round;
    logic       last_len;
  } stat_t;

  localparam logic [31:0] InitWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundConsts [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
    rotr = (x >> r) | (x << (32 - r));
  endfunction

endpackage

### sv/sha256_ctrl.sv
// Sequencer for absorb, padding, compression rounds and digest emission.
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           emit_idx,
  input  sha256_pkg::stat_t    stat,
  output sha256_pkg::cmd_t     cmd
);
  import sha256_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;
  logic [2:0] emit_cnt;
  logic take;

  assign take = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    ret_next = ret;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (!in_action) begin
            if (stat.full) begin
              state_next = ST_LOAD;
              ret_next = ST_IDLE;
            end
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (stat.full) begin
          state_next = ST_LOAD;
          ret_next = ST_ZERO;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (stat.fill == LenPos) state_next = ST_LEN;
        else if (stat.full) begin
          state_next = ST_LOAD;
          ret_next = ST_ZERO;
        end
      end
      ST_LEN: begin
        if (stat.last_len) begin
          state_next = ST_LOAD;
          ret_next = ST_EMIT;
        end
      end
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: if (stat.last_round) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ret;
      ST_EMIT: if (out_ready && emit_cnt == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.src = SRC_DATA;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.put = take && !in_action;
        cmd.count_len = take && !in_action;
      end
      ST_PAD: begin
        cmd.put = 1'b1;
        cmd.src = SRC_PAD;
      end
      ST_ZERO: begin
        cmd.put = stat.fill != LenPos;
        cmd.src = SRC_ZERO;
      end
      ST_LEN: begin
        cmd.put = 1'b1;
        cmd.src = SRC_LEN;
      end
      ST_LOAD: cmd.load = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit = 1'b1;
        cmd.reinit = out_ready && emit_cnt == 3'd7;
      end
      default: ;
    endcase
  end

  assign emit_idx = emit_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= ST_IDLE;
      emit_cnt <= '0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      if (state == ST_EMIT && out_ready) emit_cnt <= emit_cnt + 3'd1;
    end
  end

  // no word leaves outside the emit phase; input held off while busy
  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> emit_cnt == 3'd0) else $error("emit count not clear");
  a_round_after_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> state == ST_ROUND) else $error("load not followed by rounds");
endmodule

### sv/sha256_datapath.sv
// Block buffer, length counter, message schedule and round datapath.
module sha256_datapath #(
  parameter int unsigned LEN_WIDTH = sha256_pkg::LenWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  sha256_pkg::cmd_t   cmd,
  input  logic [2:0]         emit_idx,
  output sha256_pkg::stat_t  stat,
  output logic [31:0]        digest_word
);
  import sha256_pkg::*;

  logic [5:0]  fill;
  logic [LEN_WIDTH-1:0] byte_length;
  logic [63:0] bits;
  logic [31:0] cv [8];
  logic [31:0] wv [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic [2:0]  len_cnt;
  logic [7:0]  wr_byte;
  logic [31:0] w_new, w_cur, t1, t2, s0, s1, big0, big1, e, a;

  assign bits = 64'({byte_length, 3'b000});

  // select the byte to store
  always_comb begin
    case (cmd.src)
      SRC_DATA: wr_byte = data_byte;
      SRC_PAD:  wr_byte = PadByte;
      SRC_ZERO: wr_byte = 8'h00;
      default:  wr_byte = bits[8*(7-len_cnt) +: 8];
    endcase
  end

  assign stat.full = cmd.put && fill == 6'd63;
  assign stat.fill = fill;
  assign stat.last_round = rnd == 6'd63;
  assign stat.last_len = len_cnt == 3'd7;

  // schedule extension and round function
  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    w_cur = w[0];
    a = wv[0];
    e = wv[4];
    big1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    big0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    t1 = wv[7] + big1 + ((e & wv[5]) ^ (~e & wv[6])) + RoundConsts[rnd] + w_cur;
    t2 = big0 + ((a & wv[1]) ^ (a & wv[2]) ^ (wv[1] & wv[2]));
  end

  assign digest_word = cv[emit_idx];

  // counters and chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      byte_length <= '0;
      len_cnt <= '0;
      rnd <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= InitWords[i];
    end else begin
      if (cmd.put) fill <= fill + 6'd1;
      if (cmd.count_len) byte_length <= byte_length + LEN_WIDTH'(1);
      if (cmd.put && cmd.src == SRC_LEN) len_cnt <= len_cnt + 3'd1;
      if (cmd.load) rnd <= '0;
      else if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.update) begin
        for (int i = 0; i < 8; i++) cv[i] <= cv[i] + wv[i];
      end
      if (cmd.reinit) begin
        fill <= '0;
        byte_length <= '0;
        for (int i = 0; i < 8; i++) cv[i] <= InitWords[i];
      end
    end
  end

  // pack bytes big-endian into the schedule window; it slides by one word
  // each round while the working vars rotate
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
    end else if (cmd.load) begin
      for (int i = 0; i < 8; i++) wv[i] <= cv[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= e;
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= a;
      wv[0] <= t1 + t2;
    end
  end

  a_no_put_in_round: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> !cmd.put) else $error("buffer write during rounds");
  a_reinit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.reinit |=> fill == 6'd0 && byte_length == '0) else $error("reinit failed");
  a_len_at_pos: assert property (@(posedge clk) disable iff (rst)
    (cmd.put && cmd.src == SRC_LEN && len_cnt == 3'd0) |-> fill == LenPos)
    else $error("length misplaced");
endmodule

### sv/sha256_stream_hasher_core.sv
// SHA-256 stream hasher top level: joins controller and datapath.
// Absorb: one byte per cycle while idle; a full block then goes through load, 64 rounds and update
// in the shared round unit before the next byte is taken.
// Finish: padding writes one byte a cycle up to the block end, one or two compressions,
// then eight digest words, one per cycle while m_axis_tready is high.
// Synchronous active-high rst restores the initial hash words and clears the counters.
module sha256_stream_hasher_core #(
  parameter int unsigned LEN_WIDTH = sha256_pkg::LenWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_axis_tlast
);
  import sha256_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic [2:0] emit_idx;
  logic [31:0] digest_word;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_action(s_axis_tuser), .in_ready(s_axis_tready),
    .out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .emit_idx(emit_idx),
    .stat(stat), .cmd(cmd)
  );

  sha256_datapath #(.LEN_WIDTH(LEN_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .data_byte(s_axis_tdata), .cmd(cmd),
    .emit_idx(emit_idx), .stat(stat), .digest_word(digest_word)
  );

  assign m_axis_tdata = {5'd0, emit_idx, digest_word};
  assign m_axis_tlast = emit_idx == 3'd7;
endmodule
